>>> sv/mtb_pkg.sv
// Shared types and constants for the multi-timer bank.
package mtb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int SLOT_W     = 4;
    localparam int FUNC_W     = 3;
    localparam int MPT_W      = 10;
    localparam int TICKS_W    = 16;
    localparam int MS_W       = TICKS_W + MPT_W;
    localparam int WORD_W     = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_CREATE  = 3'd0,
        FN_DELETE  = 3'd1,
        FN_START   = 3'd2,
        FN_RESTART = 3'd3,
        FN_STOP    = 3'd4,
        FN_TICK    = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_EXPIRY = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [WORD_W-1:0] remaining;
        logic [WORD_W-1:0] reload;
        logic [WORD_W-1:0] utag;
    } entry_t;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic              accepted;
        logic [WORD_W-1:0] tag;
        logic              last;
    } result_t;

    typedef struct packed {
        entry_t  entry;
        logic    wr;
        logic    enlisted;
        logic    running;
        logic    emit;
        result_t res;
    } upd_t;

endpackage

>>> sv/mtb_slot_ram.sv
// Slot memory: remaining, reload and tag per slot, registered read, valid bits for reset.
module mtb_slot_ram
    import mtb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output entry_t            rd_data,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  entry_t            wr_data
);

    entry_t                  mem [NUM_TIMERS];
    entry_t                  rd_data_reg;
    logic                    rd_valid_reg;
    logic [NUM_TIMERS-1:0]   valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as the all-zero reset value
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> sv/mtb_slot_update.sv
// Next-state and result logic for one slot: a command or one step of a tick walk.
module mtb_slot_update
    import mtb_pkg::*;
(
    input  logic              tick_mode,
    input  logic [FUNC_W-1:0] func,
    input  logic [SLOT_W-1:0] slot,
    input  logic [WORD_W-1:0] timeout_ms,
    input  logic [WORD_W-1:0] tag,
    input  logic              periodic,
    input  logic [MS_W-1:0]   ms,
    input  entry_t            entry,
    input  logic              enlisted,
    input  logic              running,
    output upd_t              upd
);

    logic [WORD_W-1:0] ms_ext;
    logic [WORD_W-1:0] rem_sub;
    logic              slot_ok;

    assign ms_ext  = WORD_W'(ms);
    assign rem_sub = (entry.remaining > ms_ext) ? (entry.remaining - ms_ext) : '0;
    assign slot_ok = (32'(slot) < NUM_TIMERS);

    always_comb
    begin
        upd              = '0;
        upd.entry        = entry;
        upd.enlisted     = enlisted;
        upd.running      = running;
        upd.emit         = 1'b1;
        upd.res.kind     = KIND_ACK;
        upd.res.slot     = slot;
        upd.res.accepted = 1'b1;
        upd.res.tag      = '0;
        upd.res.last     = 1'b1;
        if (tick_mode)
        begin
            upd.emit         = 1'b0;
            upd.res.kind     = KIND_EXPIRY;
            upd.res.accepted = 1'b0;
            upd.res.last     = 1'b0;
            upd.res.tag      = entry.utag;
            if (enlisted && running)
            begin
                upd.wr              = 1'b1;
                upd.entry.remaining = rem_sub;
                if (rem_sub == '0)
                begin
                    upd.emit = 1'b1;
                    if (entry.reload != '0)
                    begin
                        upd.entry.remaining = entry.reload;
                    end
                    else
                    begin
                        upd.running = 1'b0;
                    end
                end
            end
        end
        else if (!slot_ok)
        begin
            upd.res.accepted = 1'b0;
        end
        else
        begin
            case (func_t'(func))
                FN_CREATE:
                begin
                    upd.wr           = 1'b1;
                    upd.enlisted     = 1'b1;
                    upd.entry.reload = WORD_W'(periodic);
                end
                FN_DELETE:
                begin
                    upd.enlisted = 1'b0;
                end
                FN_START:
                begin
                    if (running)
                    begin
                        upd.res.accepted = 1'b0;
                    end
                    else
                    begin
                        upd.wr              = 1'b1;
                        upd.running         = 1'b1;
                        upd.entry.remaining = timeout_ms;
                        upd.entry.utag      = tag;
                        if (entry.reload != '0)
                        begin
                            upd.entry.reload = timeout_ms;
                        end
                    end
                end
                FN_RESTART:
                begin
                    upd.wr              = 1'b1;
                    upd.running         = 1'b1;
                    upd.entry.remaining = timeout_ms;
                    upd.entry.utag      = tag;
                    upd.res.tag         = tag;
                    if (entry.reload != '0)
                    begin
                        upd.entry.reload = timeout_ms;
                    end
                end
                FN_STOP:
                begin
                    upd.running = 1'b0;
                    upd.res.tag = entry.utag;
                end
                default:
                begin
                    upd.res.accepted = 1'b0;
                end
            endcase
        end
    end

endmodule

>>> sv/multi_timer_bank_unit.sv
// Multi-timer bank: sixteen countdown slots driven by commands and tick items.
//
// Input channel (in_valid/in_ready): one transaction carries a command
// (create, delete, start, restart, stop) for one slot, or a tick with a
// count of elapsed system ticks. Output channel (out_valid/out_ready):
// result transactions; the final one for each input has last set.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes ms_per_tick; it is
// always ready; the user must write it only while the bank is idle, which
// the block does not enforce. A command reads its slot at accept and writes
// it back once the output register is free: one acknowledge. A tick reads
// slot 0 at accept, then, while no expiry waits, processes one slot a cycle
// while reading the next (read port and write port of the slot memory work
// side by side), then the done result, at once for a zero scaled time.
// The output register holds one result; when the receiver stalls and a
// new result is due, the walk halts on that slot until the register frees.
// A new input is taken as soon as the previous one has issued its last
// result into the output register.
// Reset clears all slots, flags and ms_per_tick (to 1) at once; no
// clearing pass is needed.
module multi_timer_bank_unit
    import mtb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic [SLOT_W-1:0]  slot,
    input  logic [WORD_W-1:0]  timeout_ms,
    input  logic [WORD_W-1:0]  tag,
    input  logic               periodic,
    input  logic [TICKS_W-1:0] elapsed_ticks,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [SLOT_W-1:0]  slot_out,
    output logic               accepted,
    output logic [WORD_W-1:0]  tag_out,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [MPT_W-1:0]   cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMD  = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [FUNC_W-1:0]     func_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [WORD_W-1:0]     tmo_reg;
    logic [WORD_W-1:0]     tag_reg;
    logic                  per_reg;
    logic [MS_W-1:0]       ms_reg;
    logic [MPT_W-1:0]      mpt_reg;
    logic [NUM_TIMERS-1:0] enlisted_reg;
    logic [NUM_TIMERS-1:0] running_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic                  accept;
    logic                  out_free;
    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  wr_en;
    entry_t                rd_data;
    logic [SLOT_W-1:0]     flag_addr;
    logic                  commit;
    logic                  load;
    result_t               load_res;
    upd_t                  upd;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign flag_addr = (state_reg == S_WALK) ? idx_reg : slot_reg;

    mtb_slot_update u_update (
        .tick_mode  (state_reg == S_WALK),
        .func       (func_reg),
        .slot       (flag_addr),
        .timeout_ms (tmo_reg),
        .tag        (tag_reg),
        .periodic   (per_reg),
        .ms         (ms_reg),
        .entry      (rd_data),
        .enlisted   (enlisted_reg[flag_addr]),
        .running    (running_reg[flag_addr]),
        .upd        (upd)
    );

    mtb_slot_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (flag_addr),
        .wr_data (upd.entry)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        commit     = 1'b0;
        load       = 1'b0;
        load_res   = upd.res;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_en    = 1'b1;
                    idx_next = '0;
                    if (func_t'(func) == FN_TICK)
                    begin
                        rd_addr = '0;
                        if ((elapsed_ticks == '0) || (mpt_reg == '0))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    else
                    begin
                        rd_addr    = slot;
                        state_next = S_CMD;
                    end
                end
            end
            S_CMD:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                // hold on this slot while an expiry cannot be placed
                if (!upd.emit || out_free)
                begin
                    commit = 1'b1;
                    load   = upd.emit;
                    if (idx_reg == SLOT_W'(NUM_TIMERS - 1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    load              = 1'b1;
                    load_res          = '0;
                    load_res.kind     = KIND_DONE;
                    load_res.last     = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign wr_en = commit && upd.wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            mpt_reg       <= MPT_W'(1);
            enlisted_reg  <= '0;
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready)
            begin
                mpt_reg <= cfg_data;
            end
            if (commit)
            begin
                enlisted_reg[flag_addr] <= upd.enlisted;
                running_reg[flag_addr]  <= upd.running;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            slot_reg <= slot;
            tmo_reg  <= timeout_ms;
            tag_reg  <= tag;
            per_reg  <= periodic;
            ms_reg   <= MS_W'(elapsed_ticks) * MS_W'(mpt_reg);
        end
        if (load)
        begin
            out_reg <= load_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign slot_out  = out_reg.slot;
    assign accepted  = out_reg.accepted;
    assign tag_out   = out_reg.tag;
    assign last      = out_reg.last;

    a_walk_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_WALK) |-> (idx_reg == '0))
        else $error("tick walk did not start at slot zero");

    a_no_ram_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en && (rd_addr == flag_addr)))
        else $error("slot memory read and write hit the same entry");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_reg))
        else $error("pending result overwritten");

    a_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WALK) && (state_next == S_DONE)) |-> (idx_reg == SLOT_W'(NUM_TIMERS - 1)))
        else $error("tick walk ended before the last slot");

endmodule

>>> tb/multi_timer_bank_unit_tb.sv
// Self-checking testbench for the multi-timer bank: commands, ticks and ms_per_tick scaling.
module multi_timer_bank_unit_tb;
    import mtb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 24;

    // func codes outside the defined set
    localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;

    localparam logic [MPT_W-1:0] MPT_MIN = 10'd1;
    localparam logic [MPT_W-1:0] MPT_MAX = 10'd1000;
    localparam logic [MPT_W-1:0] MPT_LOW_BITS = 10'd23;

    typedef struct {
        bit                enlisted;
        bit                running;
        logic [WORD_W-1:0] remaining;
        logic [WORD_W-1:0] reload;
        logic [WORD_W-1:0] utag;
    } slot_state_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [FUNC_W-1:0]  func = '0;
    logic [SLOT_W-1:0]  slot = '0;
    logic [WORD_W-1:0]  timeout_ms = '0;
    logic [WORD_W-1:0]  tag = '0;
    logic               periodic = 1'b0;
    logic [TICKS_W-1:0] elapsed_ticks = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         kind;
    logic [SLOT_W-1:0]  slot_out;
    logic               accepted;
    logic [WORD_W-1:0]  tag_out;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [MPT_W-1:0]   cfg_data = '0;

    slot_state_t        bank_state[NUM_TIMERS];
    logic [MPT_W-1:0]   ms_per_tick_copy = MPT_MIN;
    result_t            due_results[$];

    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    int stall_left     = 0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;
    int item_count     = 0;
    int result_count   = 0;
    int expiry_count   = 0;
    int setting_count  = 0;

    multi_timer_bank_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .slot          (slot),
        .timeout_ms    (timeout_ms),
        .tag           (tag),
        .periodic      (periodic),
        .elapsed_ticks (elapsed_ticks),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .slot_out      (slot_out),
        .accepted      (accepted),
        .tag_out       (tag_out),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
            bank_state[i] = '{1'b0, 1'b0, '0, '0, '0};
    end

    // Works out the results of one accepted item and advances the bank copy.
    task automatic predict_timer_results(input logic [FUNC_W-1:0] fn,
                                         input logic [SLOT_W-1:0] s,
                                         input logic [WORD_W-1:0] tmo,
                                         input logic [WORD_W-1:0] tg,
                                         input logic per,
                                         input logic [TICKS_W-1:0] ticks);
        logic [WORD_W-1:0] ms;
        logic              ok;
        logic [WORD_W-1:0] tag_back;
        ok = 1'b1;
        tag_back = '0;
        if (fn == FN_TICK)
        begin
            ms = WORD_W'(ticks) * WORD_W'(ms_per_tick_copy);
            if (ms != 0)
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (bank_state[i].enlisted && bank_state[i].running)
                    begin
                        bank_state[i].remaining = (bank_state[i].remaining > ms) ?
                                                  bank_state[i].remaining - ms : '0;
                        if (bank_state[i].remaining == 0)
                        begin
                            if (bank_state[i].reload != 0)
                                bank_state[i].remaining = bank_state[i].reload;
                            else
                                bank_state[i].running = 1'b0;
                            due_results.push_back('{kind: KIND_EXPIRY, slot: SLOT_W'(i),
                                                    accepted: 1'b0,
                                                    tag: bank_state[i].utag, last: 1'b0});
                        end
                    end
                end
            end
            due_results.push_back('{kind: KIND_DONE, slot: '0, accepted: 1'b0,
                                    tag: '0, last: 1'b1});
            return;
        end
        case (fn)
            FN_CREATE:
            begin
                bank_state[s].enlisted = 1'b1;
                bank_state[s].reload = per ? 32'd1 : 32'd0;
            end
            FN_DELETE:
                bank_state[s].enlisted = 1'b0;
            FN_START:
            begin
                if (bank_state[s].running)
                    ok = 1'b0;
                else
                begin
                    bank_state[s].remaining = tmo;
                    if (bank_state[s].reload != 0)
                        bank_state[s].reload = tmo;
                    bank_state[s].utag = tg;
                    bank_state[s].running = 1'b1;
                end
            end
            FN_RESTART:
            begin
                bank_state[s].remaining = tmo;
                if (bank_state[s].reload != 0)
                    bank_state[s].reload = tmo;
                bank_state[s].utag = tg;
                bank_state[s].running = 1'b1;
                tag_back = tg;
            end
            FN_STOP:
            begin
                bank_state[s].running = 1'b0;
                tag_back = bank_state[s].utag;
            end
            default:
                ok = 1'b0;
        endcase
        due_results.push_back('{kind: KIND_ACK, slot: s, accepted: ok, tag: tag_back,
                                last: 1'b1});
    endtask

    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] s,
                             input logic [WORD_W-1:0] tmo, input logic [WORD_W-1:0] tg,
                             input logic per, input logic [TICKS_W-1:0] ticks);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 13);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= fn;
        slot          <= s;
        timeout_ms    <= tmo;
        tag           <= tg;
        periodic      <= per;
        elapsed_ticks <= ticks;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_timer_results(fn, s, tmo, tg, per, ticks);
        item_count++;
    endtask

    // Command with random content in the fields it ignores
    task automatic send_command(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] s,
                                input logic [WORD_W-1:0] tmo, input logic [WORD_W-1:0] tg,
                                input logic per);
        send_item(fn, s, tmo, tg, per, TICKS_W'($urandom()));
    endtask

    task automatic send_tick(input logic [TICKS_W-1:0] ticks);
        send_item(FN_TICK, SLOT_W'($urandom()), $urandom(), $urandom(),
                  1'($urandom()), ticks);
    endtask

    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_ms_per_tick(input logic [MPT_W-1:0] value);
        wait_idle(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ms_per_tick_copy = value;
        setting_count++;
    endtask

    task automatic send_random_item();
        logic [FUNC_W-1:0]  fn;
        logic [WORD_W-1:0]  tmo;
        logic [TICKS_W-1:0] ticks;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 14)
            fn = FN_CREATE;
        else if (pick < 19)
            fn = FN_DELETE;
        else if (pick < 39)
            fn = FN_START;
        else if (pick < 49)
            fn = FN_RESTART;
        else if (pick < 57)
            fn = FN_STOP;
        else if (pick < 97)
            fn = FN_TICK;
        else if (pick < 99)
            fn = FN_RSVD6;
        else
            fn = FN_RSVD7;
        // timeouts mostly a few ticks long at the current scale
        pick = $urandom_range(0, 19);
        if (pick < 2)
            tmo = '0;
        else if (pick == 2)
            tmo = '1;
        else if (pick == 3)
            tmo = $urandom();
        else
            tmo = $urandom_range(0, 6) * ms_per_tick_copy
                  + $urandom_range(0, ms_per_tick_copy);
        pick = $urandom_range(0, 19);
        if (pick < 3)
            ticks = '0;
        else if (pick == 3)
            ticks = '1;
        else if (pick < 7)
            ticks = TICKS_W'($urandom());
        else
            ticks = TICKS_W'($urandom_range(1, 4));
        send_item(fn, SLOT_W'($urandom()), tmo, $urandom(), 1'($urandom()), ticks);
    endtask

    task automatic run_random_traffic(input int count, input logic [MPT_W-1:0] mpt,
                                      input bit pause_midway);
        write_ms_per_tick(mpt);
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_idle(0);
            send_random_item();
        end
    endtask

    task automatic test_command_set();
        send_command(FN_CREATE, 4'd0, $urandom(), $urandom(), 1'b1);
        send_command(FN_CREATE, 4'd15, $urandom(), $urandom(), 1'b0);
        send_command(FN_START, 4'd0, 32'd5, 32'hFFFF_FFFF, 1'($urandom()));
        send_command(FN_START, 4'd0, 32'd7, $urandom(), 1'($urandom()));   // refused
        send_command(FN_START, 4'd15, 32'd0, 32'd0, 1'($urandom()));
        send_command(FN_RESTART, 4'd3, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 1'($urandom()));
        send_tick(16'd0);
        send_tick(16'd3);
        send_tick(16'd2);
        send_command(FN_CREATE, 4'd3, $urandom(), $urandom(), 1'b1);
        // zero timeout drops the periodic mark
        send_command(FN_RESTART, 4'd3, 32'd0, $urandom(), 1'($urandom()));
        send_tick(16'd1);
        send_command(FN_CREATE, 4'd0, $urandom(), $urandom(), 1'b0);
        send_command(FN_DELETE, 4'd0, $urandom(), $urandom(), 1'($urandom()));
        send_tick(16'hFFFF);
        send_command(FN_CREATE, 4'd0, $urandom(), $urandom(), 1'b1);
        send_tick(16'hFFFF);
        send_command(FN_STOP, 4'd0, $urandom(), $urandom(), 1'($urandom()));
        send_command(FN_STOP, 4'd9, $urandom(), $urandom(), 1'($urandom()));
        send_command(FN_RSVD6, 4'd5, $urandom(), $urandom(), 1'($urandom()));
        send_command(FN_RSVD7, 4'd10, $urandom(), $urandom(), 1'($urandom()));
    endtask

    task automatic test_scale_extremes();
        run_random_traffic(60, MPT_MAX, 1'b0);
        run_random_traffic(60, MPT_MIN, 1'b0);
    endtask

    task automatic test_scale_midrange();
        run_random_traffic(60, MPT_LOW_BITS, 1'b1);
        run_random_traffic(60, MPT_W'($urandom_range(1, 1000)), 1'b0);
    endtask

    task automatic test_back_to_back();
        wait_idle(SETTLE_CYCLES);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        run_random_traffic(30, MPT_W'($urandom_range(1, 1000)), 1'b0);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] expv,
                               input logic [WORD_W-1:0] actv);
        if (expv !== actv)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
            mismatch_count++;
        end
    endtask

    // Result checker, receiver stalls and watchdog
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                if (due_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none, actual %0h %0h %0h %0h %0h",
                             $time, kind, slot_out, accepted, tag_out, last);
                    mismatch_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (kind == KIND_EXPIRY)
                        expiry_count++;
                    check_field("kind", WORD_W'(want.kind), WORD_W'(kind));
                    check_field("slot_out", WORD_W'(want.slot), WORD_W'(slot_out));
                    check_field("accepted", WORD_W'(want.accepted), WORD_W'(accepted));
                    check_field("tag_out", want.tag, tag_out);
                    check_field("last", WORD_W'(want.last), WORD_W'(last));
                end
            end
            if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, no transaction for %0d cycles", $time,
                         quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (receiver_idles && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_command_set();
        test_scale_extremes();
        test_scale_midrange();
        test_back_to_back();
        wait_idle(SETTLE_CYCLES);
        $display("Sent %0d items across %0d ms_per_tick settings (1, 1000, 23 and random).",
                 item_count, setting_count);
        $display("Checked %0d results, %0d of them timer expiries.", result_count,
                 expiry_count);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
